[src/lacc_pkg.sv]
// Shared types and constants for the logic analyzer command and capture block.
package lacc_pkg;

  // Host command codes.
  localparam logic [7:0] CMD_RESET   = 8'h00;
  localparam logic [7:0] CMD_RUN     = 8'h01;
  localparam logic [7:0] CMD_ID      = 8'h02;
  localparam logic [7:0] CMD_DESC    = 8'h04;
  localparam logic [7:0] CMD_XON     = 8'h11;
  localparam logic [7:0] CMD_XOFF    = 8'h13;
  localparam logic [7:0] CMD_TRIGGER = 8'hC0;
  localparam logic [7:0] CMD_COUNT   = 8'h81;
  localparam logic [7:0] CMD_DIVIDER = 8'h80;

  localparam logic [21:0] PERIOD_RESET = 22'h640;
  localparam int ID_LEN   = 4;
  localparam int DESC_LEN = 21;

  // Reply burst selected by the front part.
  typedef enum logic [1:0] {
    RPL_NONE = 2'd0,
    RPL_ID   = 2'd1,
    RPL_DESC = 2'd2
  } reply_t;

  // One queue entry: a reply request or a sample to send.
  typedef struct packed {
    logic   is_sample;
    logic   last;
    logic [7:0] data;
    reply_t reply;
  } job_t;

  // Identity string byte.
  function automatic logic [7:0] id_byte(input logic [1:0] i);
    logic [7:0] b;
    unique case (i)
      2'd0: b = 8'h31;
      2'd1: b = 8'h41;
      2'd2: b = 8'h4C;
      default: b = 8'h53;
    endcase
    return b;
  endfunction

endpackage

[src/lacc_front.sv]
// Command decoder and capture engine: classifies each transaction and queues work.
module lacc_front
  import lacc_pkg::*;
#(
  parameter int SAMPLE_DEPTH = 4096,
  parameter int PROBE_COUNT  = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  host_byte,
  input  logic [7:0]  probe_pins,
  output logic        job_valid,
  output job_t        job,
  input  logic        job_ready
);

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_COLLECT = 4'b0010,
    PH_ARMED   = 4'b0100,
    PH_CAPTURE = 4'b1000
  } phase_t;

  localparam int CW = $clog2(SAMPLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(SAMPLE_DEPTH);
  localparam logic [7:0] PMASK = 8'((1 << PROBE_COUNT) - 1);

  phase_t phase_r, phase_nxt;
  logic [7:0]  opcode_r, opcode_nxt;
  logic [23:0] args_r, args_nxt;
  logic [2:0]  nb_r, nb_nxt;
  logic [7:0]  tmask_r, tmask_nxt;
  logic [CW-1:0] total_r, total_nxt, taken_r, taken_nxt;
  logic [21:0] period_r, period_nxt, tcnt_r, tcnt_nxt;
  logic [7:0]  prev_r, prev_nxt;
  // Divider command: pipelined multiply by reciprocal of 25.
  logic        dv_r;
  logic [26:0] dv_x_r;
  logic [59:0] dv_q_r;
  logic        dv2_r;

  logic [7:0]  pins;
  logic        acc, emit, rst_cmd;
  logic [CW-1:0] taken_inc;
  logic [18:0] cnt_v;

  assign pins = probe_pins & PMASK;
  assign in_ready = job_ready;
  assign acc = in_valid && in_ready;
  assign taken_inc = taken_r + CW'(1);
  assign cnt_v = ({3'b0, args_r[15:0]} + 19'd1) << 2;
  // A reset command cancels a divider result still in the pipeline.
  assign rst_cmd = acc && !req_type && phase_r == PH_IDLE && host_byte == CMD_RESET;

  always_comb begin
    phase_nxt = phase_r; opcode_nxt = opcode_r; args_nxt = args_r; nb_nxt = nb_r;
    tmask_nxt = tmask_r; total_nxt = total_r; period_nxt = period_r;
    tcnt_nxt = tcnt_r; taken_nxt = taken_r; prev_nxt = prev_r;
    emit = 1'b0;
    job_valid = 1'b0;
    job = '{is_sample: 1'b0, last: 1'b0, data: pins, reply: RPL_NONE};
    // Divider result lands once it has passed the operand and product registers.
    if (dv2_r) begin
      period_nxt = (dv_q_r[53:32] > 22'd16) ? dv_q_r[53:32] - 22'd16 : 22'd1;
    end
    if (acc && req_type) begin
      // Sample-clock tick.
      prev_nxt = pins;
      unique case (phase_r)
        PH_ARMED: if (tmask_r == '0 || ((pins ^ prev_r) & tmask_r) != '0) begin
          phase_nxt = PH_CAPTURE;
          emit = 1'b1;
          taken_nxt = CW'(1);
        end
        PH_CAPTURE: if (tcnt_r >= period_r) begin
          emit = 1'b1;
          taken_nxt = taken_inc;
        end else begin
          tcnt_nxt = tcnt_r + 22'd1;
        end
        default: ;
      endcase
      if (emit) begin
        tcnt_nxt = '0;
        job_valid = 1'b1;
        job.is_sample = 1'b1;
        job.last = (taken_nxt >= total_r);
        if (job.last) begin
          phase_nxt = PH_IDLE; opcode_nxt = '0; args_nxt = '0; nb_nxt = '0;
          tmask_nxt = '0; total_nxt = DEPTH_C; period_nxt = PERIOD_RESET;
          tcnt_nxt = '0; taken_nxt = '0;
        end
      end
    end else if (acc) begin
      // Host command byte.
      unique case (phase_r)
        PH_COLLECT: begin
          if (nb_r < 3'd3) args_nxt = args_r | (24'(host_byte) << {nb_r[1:0], 3'b0});
          nb_nxt = nb_r + 3'd1;
          if (nb_r == 3'd3) begin
            if (opcode_r == CMD_TRIGGER) tmask_nxt = tmask_r | (args_r[7:0] & PMASK);
            else if (opcode_r == CMD_COUNT)
              total_nxt = (cnt_v > 19'(SAMPLE_DEPTH)) ? DEPTH_C : CW'(cnt_v);
            phase_nxt = PH_IDLE; opcode_nxt = '0; args_nxt = '0; nb_nxt = '0;
          end
        end
        PH_IDLE: begin
          priority case (host_byte)
            CMD_RESET: begin
              opcode_nxt = '0; args_nxt = '0; nb_nxt = '0; tmask_nxt = '0;
              total_nxt = DEPTH_C; period_nxt = PERIOD_RESET;
              tcnt_nxt = '0; taken_nxt = '0;
            end
            CMD_RUN: begin
              tcnt_nxt = '0; taken_nxt = '0; phase_nxt = PH_ARMED;
            end
            CMD_ID: begin
              job_valid = 1'b1; job.reply = RPL_ID;
            end
            CMD_DESC: begin
              job_valid = 1'b1; job.reply = RPL_DESC;
            end
            CMD_XON, CMD_XOFF: ;
            default: begin
              opcode_nxt = host_byte; args_nxt = '0; nb_nxt = '0;
              phase_nxt = PH_COLLECT;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; opcode_r <= '0; args_r <= '0; nb_r <= '0; tmask_r <= '0;
      total_r <= DEPTH_C; period_r <= PERIOD_RESET; tcnt_r <= '0; taken_r <= '0;
      prev_r <= '0; dv_r <= 1'b0; dv2_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; opcode_r <= opcode_nxt; args_r <= args_nxt;
      nb_r <= nb_nxt; tmask_r <= tmask_nxt; total_r <= total_nxt;
      period_r <= period_nxt; tcnt_r <= tcnt_nxt; taken_r <= taken_nxt;
      prev_r <= prev_nxt;
      dv_r <= acc && !req_type && phase_r == PH_COLLECT && nb_r == 3'd3
              && opcode_r == CMD_DIVIDER;
      dv2_r <= dv_r && !rst_cmd;
    end
  end

  // Operand and product registers for the divide by 25 (floor(x*k/2^32), k=ceil(2^32/25)).
  always_ff @(posedge clk) begin
    dv_x_r <= ({3'b0, args_r} + 27'd1) << 2;
    dv_q_r <= 60'(dv_x_r) * 60'd171798692;
  end

endmodule

[src/lacc_back.sv]
// Output sequencer: plays reply bursts and samples from the queue onto the result stream.
module lacc_back
  import lacc_pkg::*;
#(
  parameter int SAMPLE_DEPTH = 4096,
  parameter int PROBE_COUNT  = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_ready,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tuser,
  output logic       out_tlast
);

  localparam logic [31:0] DEPTH32 = 32'(SAMPLE_DEPTH);

  // Two-entry queue between decoder and sequencer.
  job_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  reply_t     cur_r;
  logic [4:0] idx_r;
  logic       busy, pop, push, take;
  job_t       head;
  logic [7:0] rb;
  logic       rlast;

  assign head = q_r[rd_r];
  assign busy = cur_r != RPL_NONE;
  assign take = !out_tvalid || out_tready;
  assign pop  = cnt_r != 2'd0 && !busy && take;
  assign push = job_valid && job_ready;
  assign job_ready = cnt_r != 2'd2;
  assign cnt_nxt = cnt_r + 2'(push) - 2'(pop);

  // Reply byte for the running burst.
  always_comb begin
    rb = 8'h00;
    rlast = 1'b0;
    if (cur_r == RPL_ID) begin
      rb = id_byte(idx_r[1:0]);
      rlast = idx_r == 5'(ID_LEN - 1);
    end else begin
      rlast = idx_r == 5'(DESC_LEN - 1);
      unique case (idx_r)
        5'd0: rb = 8'h01; 5'd1: rb = 8'h42; 5'd2: rb = 8'h50; 5'd3: rb = 8'h76;
        5'd4: rb = 8'h33; 5'd5: rb = 8'h00; 5'd6: rb = 8'h21;
        5'd7: rb = DEPTH32[31:24]; 5'd8: rb = DEPTH32[23:16];
        5'd9: rb = DEPTH32[15:8]; 5'd10: rb = DEPTH32[7:0];
        5'd11: rb = 8'h23; 5'd12: rb = 8'h00; 5'd13: rb = 8'h0F; 5'd14: rb = 8'h42;
        5'd15: rb = 8'h40; 5'd16: rb = 8'h40; 5'd17: rb = 8'(PROBE_COUNT);
        5'd18: rb = 8'h41; 5'd19: rb = 8'h02;
        default: rb = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= job;
  end

  // Output register and burst sequencing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; rd_r <= 1'b0; wr_r <= 1'b0; cur_r <= RPL_NONE; idx_r <= '0;
      out_tvalid <= 1'b0; out_tdata <= '0; out_tuser <= 1'b0; out_tlast <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= !wr_r;
      if (busy && take) begin
        out_tvalid <= 1'b1; out_tdata <= rb; out_tuser <= 1'b0; out_tlast <= rlast;
        idx_r <= idx_r + 5'd1;
        if (rlast) begin
          cur_r <= RPL_NONE; idx_r <= '0;
        end
      end else if (pop) begin
        rd_r <= !rd_r;
        if (head.is_sample) begin
          out_tvalid <= 1'b1; out_tdata <= head.data; out_tuser <= 1'b1;
          out_tlast <= head.last;
        end else begin
          out_tvalid <= 1'b0; cur_r <= head.reply; idx_r <= '0;
        end
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

endmodule

[src/logic_analyzer_command_and_capture.sv]
// Top level of the logic analyzer command decoder and capture engine.
//  channel | direction | contents
//  in_     | slave     | tdata: host_byte, probe_pins; tuser: req_type
//  out_    | master    | tdata: out_byte; tuser: out_kind; tlast: out_last
// One input transaction a cycle while the two-entry job queue has room.
// Samples pass through the job queue and the output register; a reply burst plays one
// byte per cycle from the sequencer while out_tready allows, 4 bytes for ID and 21 for DESC.
// The divider command updates the period from its last byte through the operand and product registers.
// Reset is synchronous; out_tready low stalls the sequencer and then the queue.
module logic_analyzer_command_and_capture
  import lacc_pkg::*;
#(
  parameter int SAMPLE_DEPTH = 4096,
  parameter int PROBE_COUNT  = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // host_byte, probe_pins
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte
  output logic        out_tuser,  // out_kind
  output logic        out_tlast
);

  logic job_valid, job_ready;
  job_t job;

  lacc_front #(.SAMPLE_DEPTH(SAMPLE_DEPTH), .PROBE_COUNT(PROBE_COUNT)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .req_type(in_tuser),
    .host_byte(in_tdata[7:0]), .probe_pins(in_tdata[15:8]),
    .job_valid, .job, .job_ready
  );

  lacc_back #(.SAMPLE_DEPTH(SAMPLE_DEPTH), .PROBE_COUNT(PROBE_COUNT)) u_back (
    .clk, .rst_n, .job_valid, .job, .job_ready,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

`ifndef NO_ASSERTIONS
  // A job offered to a full queue is never accepted.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && !job_ready |-> !(in_tvalid && in_tready)) else $error("queue overflow");
  // Captured samples fit within the probe width.
  a_sample_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata >> PROBE_COUNT) == 8'h00)
    else $error("sample wider than probes");
`endif

endmodule

[tb/logic_analyzer_command_and_capture_tb.sv]
// Testbench for the logic analyzer command decoder and capture engine.
module logic_analyzer_command_and_capture_tb;
  import lacc_pkg::*;

  localparam int DEPTH  = 4096;
  localparam int PROBES = 5;
  localparam logic [7:0] PIN_MASK = 8'((1 << PROBES) - 1);
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic       is_tick;
    logic [7:0] pins;
    logic [7:0] host_byte;
  } stim_t;

  typedef struct packed {
    logic [7:0] data;
    logic       kind;
    logic       last;
  } reply_item_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0, ST_COLLECT = 2'd1, ST_ARMED = 2'd2, ST_CAPTURE = 2'd3
  } la_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  stim_t pending_items[$];
  reply_item_t expected_bytes[$];
  int errors = 0;
  int send_idle_pct = 31;
  int recv_idle_pct = 49;
  int hold_off_cycles = 0;
  int quiet_cycles = 0;

  // Shadow state of the analyzer.
  la_state_t  sh_state;
  logic [7:0] sh_opcode;
  logic [23:0] sh_args;
  int unsigned sh_count;
  logic [7:0] sh_mask;
  int unsigned sh_total;
  int unsigned sh_period;
  int unsigned sh_ticks;
  int unsigned sh_taken;
  logic [7:0] sh_prev;

  logic_analyzer_command_and_capture dut (.*);

  always #10 clk = ~clk;

  function automatic void shadow_defaults();
    sh_state = ST_IDLE; sh_opcode = '0; sh_args = '0; sh_count = 0; sh_mask = '0;
    sh_total = DEPTH; sh_period = 32'(PERIOD_RESET); sh_ticks = 0; sh_taken = 0;
  endfunction

  function automatic void push_byte(logic [7:0] d, logic kind, logic last);
    expected_bytes.push_back('{data: d, kind: kind, last: last});
  endfunction

  function automatic void push_sample(logic [7:0] pins);
    sh_taken++;
    sh_ticks = 0;
    push_byte(pins, 1'b1, sh_taken >= sh_total);
    if (sh_taken >= sh_total) shadow_defaults();
  endfunction

  // Predict the result bytes caused by one accepted transaction.
  function automatic void predict_analyzer(stim_t it);
    logic [7:0] pins, prev, b1, b2;
    int unsigned v;
    logic [7:0] desc[21];
    pins = it.pins & PIN_MASK;
    b1 = sh_args[7:0];
    b2 = sh_args[15:8];
    if (it.is_tick) begin
      prev = sh_prev;
      sh_prev = pins;
      if (sh_state == ST_ARMED) begin
        if (sh_mask == 0 || ((pins ^ prev) & sh_mask) != 0) begin
          sh_state = ST_CAPTURE;
          sh_taken = 0;
          push_sample(pins);
        end
      end else if (sh_state == ST_CAPTURE) begin
        if (sh_ticks >= sh_period) push_sample(pins);
        else sh_ticks++;
      end
      return;
    end
    if (sh_state == ST_COLLECT) begin
      if (sh_count < 3) sh_args |= 24'(it.host_byte) << (8 * sh_count);
      sh_count++;
      if (sh_count >= 4) begin
        b1 = sh_args[7:0];
        b2 = sh_args[15:8];
        if (sh_opcode == CMD_TRIGGER) begin
          sh_mask |= b1 & PIN_MASK;
        end else if (sh_opcode == CMD_COUNT) begin
          v = ({b2, b1} + 1) * 4;
          sh_total = v > DEPTH ? DEPTH : v;
        end else if (sh_opcode == CMD_DIVIDER) begin
          v = ((32'(sh_args) + 1) * 4) / 25;
          sh_period = v > 16 ? v - 16 : 1;
        end
        sh_state = ST_IDLE; sh_opcode = '0; sh_args = '0; sh_count = 0;
      end
      return;
    end
    if (sh_state != ST_IDLE) return;
    case (it.host_byte)
      CMD_RESET: shadow_defaults();
      CMD_RUN: begin
        sh_ticks = 0; sh_taken = 0; sh_state = ST_ARMED;
      end
      CMD_ID: begin
        push_byte(8'h31, 1'b0, 1'b0); push_byte(8'h41, 1'b0, 1'b0);
        push_byte(8'h4C, 1'b0, 1'b0); push_byte(8'h53, 1'b0, 1'b1);
      end
      CMD_DESC: begin
        desc = '{8'h01, 8'h42, 8'h50, 8'h76, 8'h33, 8'h00, 8'h21,
                 8'(DEPTH >> 24), 8'(DEPTH >> 16), 8'(DEPTH >> 8), 8'(DEPTH),
                 8'h23, 8'h00, 8'h0F, 8'h42, 8'h40, 8'h40, 8'(PROBES),
                 8'h41, 8'h02, 8'h00};
        foreach (desc[i]) push_byte(desc[i], 1'b0, i == 20);
      end
      CMD_XON, CMD_XOFF: ;
      default: begin
        sh_opcode = it.host_byte; sh_args = '0; sh_count = 0; sh_state = ST_COLLECT;
      end
    endcase
  endfunction

  function automatic void add_cmd(logic [7:0] b);
    pending_items.push_back('{is_tick: 1'b0, host_byte: b, pins: 8'($urandom)});
  endfunction

  function automatic void add_tick(logic [7:0] p);
    pending_items.push_back('{is_tick: 1'b1, host_byte: 8'($urandom), pins: p});
  endfunction

  function automatic void add_long(logic [7:0] op, logic [7:0] a1, logic [7:0] a2,
                                   logic [7:0] a3);
    add_cmd(op); add_cmd(a1); add_cmd(a2); add_cmd(a3); add_cmd(8'($urandom));
  endfunction

  // A capture run with short count and period, then enough ticks to finish it.
  function automatic void add_capture();
    int unsigned n, per, samples;
    logic [7:0] p;
    n = $urandom_range(0, 1);
    samples = (n + 1) * 4;
    add_long(CMD_COUNT, 8'(n), 8'h00, 8'($urandom));
    // Divider arguments of 0..130 give periods of 1..4.
    add_long(CMD_DIVIDER, 8'($urandom_range(0, 130)), 8'h00, 8'h00);
    if ($urandom_range(0, 1)) add_long(CMD_TRIGGER, 8'($urandom), 8'($urandom), 8'($urandom));
    add_cmd(CMD_RUN);
    per = 5;
    p = 8'($urandom);
    for (int i = 0; i < samples * per + 30; i++) begin
      if ($urandom_range(0, 3) == 0) p = 8'($urandom);
      add_tick(p);
    end
  endfunction

  // Driver: offers the next pending transaction with random gaps.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (in_tvalid) predict_analyzer(stim_t'({in_tuser, in_tdata}));
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          {in_tuser, in_tdata} <= pending_items.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness, with a long hold-off in the first random phase.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: checks each result transaction against the oldest expectation.
  always @(posedge clk) begin
    reply_item_t exp_b;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: byte %h kind %b last %b", out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        exp_b = expected_bytes.pop_front();
        if (out_tdata !== exp_b.data) begin
          $error("out_byte: expected %h, got %h", exp_b.data, out_tdata); errors++;
        end
        if (out_tuser !== exp_b.kind) begin
          $error("out_kind: expected %b, got %b", exp_b.kind, out_tuser); errors++;
        end
        if (out_tlast !== exp_b.last) begin
          $error("out_last: expected %b, got %b", exp_b.last, out_tlast); errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("logic_analyzer_command_and_capture_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int sel;
    shadow_defaults();
    sh_prev = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: first tick against reset pins, short commands, long commands.
    add_tick(8'hFF); add_tick(8'h00);
    add_cmd(CMD_ID); add_cmd(CMD_DESC); add_cmd(CMD_XON); add_cmd(CMD_XOFF);
    add_long(8'h55, 8'hFF, 8'hFF, 8'hFF);
    add_long(CMD_COUNT, 8'hFF, 8'hFF, 8'h00);
    add_long(CMD_DIVIDER, 8'hFF, 8'hFF, 8'hFF);
    add_cmd(CMD_RESET);
    add_long(CMD_COUNT, 8'h00, 8'h00, 8'h00);
    add_long(CMD_DIVIDER, 8'h00, 8'h00, 8'h00);
    add_cmd(CMD_RUN);
    add_cmd(CMD_ID);
    for (int i = 0; i < 8; i++) add_tick(8'(i * 37));
    wait (pending_items.size() == 0 && expected_bytes.size() == 0);

    // Random phases with three idling patterns; the first has a long stall.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 49 : 0;
      recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 31 : 0;
      if (ph == 0) begin
        add_cmd(CMD_DESC); add_cmd(CMD_DESC); add_cmd(CMD_ID);
        hold_off_cycles = 300;
      end
      for (int k = 0; k < 2; k++) begin
        add_capture();
        for (int j = 0; j < 6; j++) begin
          sel = $urandom_range(0, 9);
          if (sel < 3) add_cmd(CMD_ID);
          else if (sel == 3) add_cmd(CMD_DESC);
          else if (sel < 6) add_tick(8'($urandom));
          else if (sel == 6) add_cmd(8'($urandom));
          else if (sel == 7) add_cmd(CMD_RESET);
          else add_long(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
      end
      wait (pending_items.size() == 0 && !in_tvalid && expected_bytes.size() == 0);
    end

    repeat (50) @(posedge clk);
    if (errors == 0 && expected_bytes.size() == 0)
      $display("logic_analyzer_command_and_capture_tb: PASS");
    else
      $display("logic_analyzer_command_and_capture_tb: FAIL");
    $finish;
  end
endmodule

[logic_analyzer_command_and_capture.f]
src/lacc_pkg.sv
src/lacc_front.sv
src/lacc_back.sv
src/logic_analyzer_command_and_capture.sv
tb/logic_analyzer_command_and_capture_tb.sv
